@@ rtl/core/sliding_window_maximum_assert.svh @@
// Assertion macros shared by the sliding window maximum RTL.
`ifndef SLIDING_WINDOW_MAXIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset.
`define SWM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sliding window maximum check failed");

// Next-cycle implication, disabled in reset.
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sliding window maximum check failed");

`else

`define SWM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/swm_pkg.sv @@
// Shared types and constants of the sliding window maximum block.
`default_nettype none

package swm_pkg;

   localparam int CSR_WIDTH = 7;
   localparam int CSR_RESET = 3;

   typedef struct packed {
      logic advance;   // a sample transaction is taken this cycle
      logic restart;   // the sample begins a new stream
      logic shift;     // the front candidate leaves; every cell takes its right neighbor
      logic flush;     // window size written: empty the queue
   } swm_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/swm_cell.sv @@
// One entry of the monotonic candidate queue.
`default_nettype none

module swm_cell #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int AGE_WIDTH    = 7
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire swm_pkg::swm_ctrl_type          ctrl,
   input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
   input  wire logic                           prev_keep,
   input  wire logic                           right_valid,
   input  wire logic signed [SAMPLE_WIDTH-1:0] right_value,
   input  wire logic        [AGE_WIDTH-1:0]    right_age,
   output      logic                           valid,
   output      logic signed [SAMPLE_WIDTH-1:0] value,
   output      logic        [AGE_WIDTH-1:0]    age,
   output      logic                           keep,
   output      logic signed [SAMPLE_WIDTH-1:0] next_value
);
   import swm_pkg::*;

   logic                           valid_ff, valid_in;
   logic signed [SAMPLE_WIDTH-1:0] value_ff, value_in;
   logic        [AGE_WIDTH-1:0]    age_ff, age_in;
   logic                           src_valid;
   logic signed [SAMPLE_WIDTH-1:0] src_value;
   logic        [AGE_WIDTH-1:0]    src_age;

   always_comb begin
      src_valid = ctrl.shift ? right_valid : valid_ff;
      src_value = ctrl.shift ? right_value : value_ff;
      src_age   = ctrl.shift ? right_age   : age_ff;
      // keep only strictly larger candidates of the current stream
      keep = src_valid && !ctrl.restart && (src_value > sample);
      if (keep) begin
         valid_in = 1'b1;
         value_in = src_value;
         age_in   = src_age + AGE_WIDTH'(1);
      end else if (prev_keep) begin
         valid_in = 1'b1;
         value_in = sample;
         age_in   = '0;
      end else begin
         valid_in = 1'b0;
         value_in = value_ff;
         age_in   = age_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.flush) begin
         valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign valid      = valid_ff;
   assign value      = value_ff;
   assign age        = age_ff;
   assign next_value = value_in;

endmodule

`default_nettype wire

@@ rtl/core/sliding_window_maximum.sv @@
// Top level of the sliding window maximum block: control, window register, cell row.
// A result is registered on rsp_ in the cycle after its sample transaction is accepted.
// Throughput: 1 sample per cycle while req_stall is low; the whole cell row updates at once.
// A sample is accepted while the output register is empty or being emptied.
// Reset (synchronous): queue empty, sample count zero, window size 3, no result.
`default_nettype none

module sliding_window_maximum #(
   parameter int MAX_WINDOW   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]     req_sample,
   input  wire logic                               req_restart,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic signed [SAMPLE_WIDTH-1:0]     rsp_window_max,
   input  wire logic                               csr_wr_en,
   input  wire logic        [swm_pkg::CSR_WIDTH-1:0] csr_wr_data
);
   import swm_pkg::*;

`include "sliding_window_maximum_assert.svh"

   // Ages stay below the window, the window never exceeds MAX_WINDOW.
   localparam int WW         = $clog2(MAX_WINDOW + 1);
   localparam int WIN_RESET  = (CSR_RESET > MAX_WINDOW) ? MAX_WINDOW : CSR_RESET;

   // Effective window size, clamped to 1..MAX_WINDOW when written.
   logic [WW-1:0] window_ff, window_in;
   // Samples since the last restart or window size write, saturating at MAX_WINDOW.
   logic [WW-1:0] seen_ff, seen_in, seen_base;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_max_ff;

   logic          req_accept;
   logic          result_ready;
   swm_ctrl_type  ctrl;

   // Cell row: index MAX_WINDOW is an always-empty neighbor past the back.
   logic                           cell_valid [MAX_WINDOW+1];
   logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW+1];
   logic        [WW-1:0]           cell_age   [MAX_WINDOW+1];
   logic signed [SAMPLE_WIDTH-1:0] cell_next  [MAX_WINDOW];
   logic        [MAX_WINDOW:0]     keep_vec;
   logic        [MAX_WINDOW-1:0]   valid_vec;
   logic signed [SAMPLE_WIDTH-1:0] front_next;

   // Handshake: hold the sample side only while a result waits and is stalled.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Window size register; a write also restarts the stream.
   always_comb begin
      if (csr_wr_data == '0) begin
         window_in = WW'(1);
      end else if (32'(csr_wr_data) > MAX_WINDOW) begin
         window_in = WW'(MAX_WINDOW);
      end else begin
         window_in = WW'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WW'(WIN_RESET);
      end else if (csr_wr_en) begin
         window_ff <= window_in;
      end
   end

   // Cell row control. Ages are distinct and below the window, so at most the
   // front candidate can expire per sample; drop it by shifting the row left.
   always_comb begin
      ctrl.advance = req_accept;
      ctrl.restart = req_restart;
      ctrl.flush   = csr_wr_en;
      ctrl.shift   = !req_restart && cell_valid[0] &&
                     ((cell_age[0] + WW'(1)) >= window_ff);
   end

   // Sample count: clear on restart, advance with saturation.
   always_comb begin
      seen_base    = req_restart ? '0 : seen_ff;
      seen_in      = (32'(seen_base) < MAX_WINDOW) ? seen_base + WW'(1) : seen_base;
      result_ready = seen_in >= window_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (csr_wr_en) begin
         seen_ff <= '0;
      end else if (req_accept) begin
         seen_ff <= seen_in;
      end
   end

   assign keep_vec[0]            = 1'b1;
   assign cell_valid[MAX_WINDOW] = 1'b0;
   assign cell_value[MAX_WINDOW] = '0;
   assign cell_age[MAX_WINDOW]   = '0;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      swm_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .AGE_WIDTH    (WW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .sample      (req_sample),
         .prev_keep   (keep_vec[i]),
         .right_valid (cell_valid[i+1]),
         .right_value (cell_value[i+1]),
         .right_age   (cell_age[i+1]),
         .valid       (cell_valid[i]),
         .value       (cell_value[i]),
         .age         (cell_age[i]),
         .keep        (keep_vec[i+1]),
         .next_value  (cell_next[i])
      );
      assign valid_vec[i] = cell_valid[i];
   end

   // Only the front cell's next value matters: it is the new window maximum.
   assign front_next = cell_next[0];

   // Output register: load on a full-window sample, drop once taken.
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = result_ready;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The front after the update is the window maximum.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_max_ff <= front_next;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;

   // Occupied cells form a contiguous run from the front.
   `SWM_ASSERT_IMPLY(a_valid_contiguous, clock, reset, 1'b1,
                     (valid_vec & (valid_vec + 1'b1)) == '0)
   // The queue never holds more candidates than the window.
   `SWM_ASSERT_IMPLY(a_count_in_window, clock, reset, 1'b1,
                     $countones(valid_vec) <= 32'(window_ff))
   // No candidate ever has to be kept past the back of the row.
   `SWM_ASSERT_IMPLY(a_no_overflow, clock, reset, 1'b1, !keep_vec[MAX_WINDOW])
   // A full-window sample always produces a result.
   `SWM_ASSERT_NEXT(a_result_loaded, clock, reset, req_accept && result_ready,
                    rsp_valid_ff)
   // A window size write empties the queue.
   `SWM_ASSERT_NEXT(a_write_flushes, clock, reset, csr_wr_en,
                    !cell_valid[0] && (seen_ff == '0))

endmodule

`default_nettype wire

@@ test/tb_sliding_window_maximum.sv @@
// Self-checking testbench for the sliding window maximum block.
`timescale 1ns / 100ps

module tb_sliding_window_maximum;

   import swm_pkg::*;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 16;
   localparam int STALL_LIMIT  = 2000;   // cycles without any transaction before giving up
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off of the pressure phase
   localparam int DRAIN_CYCLES = 4;      // settle time after the last result

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct {
      sample_type sample;
      logic       restart;
   } stream_sample_type;

   // Clock, reset and every block input start at a known value.
   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   sample_type             req_sample     = '0;
   logic                   req_restart    = 1'b0;
   logic                   rsp_stall      = 1'b0;
   logic                   csr_wr_en      = 1'b0;
   logic [CSR_WIDTH-1:0]   csr_wr_data    = '0;
   logic                   req_stall;
   logic                   rsp_valid;
   sample_type             rsp_window_max;

   // Samples waiting to be offered, and window maxima waiting to come out.
   stream_sample_type pending_samples[$];
   sample_type        expected_max[$];

   // Shadow of the block: window register and the monotonic candidate queue.
   logic [CSR_WIDTH-1:0] win_size = CSR_RESET[CSR_WIDTH-1:0];
   sample_type           cand_val [MAX_WINDOW];
   int                   cand_age [MAX_WINDOW];
   int                   cand_count   = 0;
   int                   samples_seen = 0;

   // Traffic knobs, set per phase.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;

   // Run statistics.
   int mismatch_count = 0;
   int samples_taken  = 0;
   int restarts_taken = 0;
   int maxima_checked = 0;
   int window_writes  = 0;
   int quiet_cycles   = 0;
   sample_type last_sample = '0;

   sliding_window_maximum #(
      .MAX_WINDOW   (MAX_WINDOW),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_window_max (rsp_window_max),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what, input sample_type got,
                                  input sample_type want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Append one sample to the tail of the pending queue.
   task automatic queue_sample(input sample_type s, input logic restart);
      stream_sample_type t;
      t.sample  = s;
      t.restart = restart;
      pending_samples.insert(pending_samples.size(), t);
   endtask

   // Advance the shadow queue by one sample; queue a window maximum once the window is full.
   function automatic void predict_window_max(input sample_type s, input logic restart);
      int w;
      int drop;
      int k;
      w = (win_size == 0) ? 1 : ((win_size > MAX_WINDOW) ? MAX_WINDOW : int'(win_size));
      if (restart) begin
         cand_count   = 0;
         samples_seen = 0;
      end
      // Age every candidate, then drop the ones at the front that left the window.
      for (k = 0; k < cand_count; k++)
         cand_age[k]++;
      drop = 0;
      while (drop < cand_count && cand_age[drop] >= w)
         drop++;
      for (k = 0; k < cand_count - drop; k++) begin
         cand_val[k] = cand_val[k + drop];
         cand_age[k] = cand_age[k + drop];
      end
      cand_count -= drop;
      // Drop candidates at the back that are not larger; equal older values go too.
      while (cand_count > 0 && cand_val[cand_count - 1] <= s)
         cand_count--;
      if (cand_count < MAX_WINDOW) begin
         cand_val[cand_count] = s;
         cand_age[cand_count] = 0;
         cand_count++;
      end
      if (samples_seen < MAX_WINDOW)
         samples_seen++;
      if (samples_seen >= w)
         expected_max.insert(expected_max.size(), cand_val[0]);
   endfunction

   // Pick the next random sample. Mix extremes, falling runs (deep queues), repeats
   // (equal-value drops) and a narrow band around zero into plain random values.
   function automatic stream_sample_type random_sample();
      stream_sample_type t;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: t.sample = 16'h7FFF;
               1: t.sample = 16'h8000;
               2: t.sample = 16'h0000;
               default: t.sample = 16'hFFFF;
            endcase
         end
         1, 2: t.sample = last_sample - sample_type'($urandom_range(40, 1));
         3: t.sample = last_sample;
         4: t.sample = sample_type'($urandom_range(8)) - sample_type'(4);
         default: t.sample = sample_type'($urandom);
      endcase
      // Keep restarts rare so that even the widest window fills.
      t.restart   = ($urandom_range(199) == 0);
      last_sample = t.sample;
      return t;
   endfunction

   // Hold until every queued sample has gone in and every maximum has come out.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_max.size() != 0);
   endtask

   // Write the window size; the block clears its stream on the write, so clear the shadow too.
   task automatic write_window(input logic [CSR_WIDTH-1:0] size);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      win_size     = size;
      cand_count   = 0;
      samples_seen = 0;
      window_writes++;
      csr_wr_en   <= 1'b0;
   endtask

   // One phase: drain, let the last sample settle, retune the window, set traffic, queue samples.
   task automatic run_phase(input logic [CSR_WIDTH-1:0] size, input int n_samples,
                            input int idle_pct, input int stall_pct, input bit hold_off);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_window(size);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (hold_off)
         hold_requests++;
      repeat (n_samples)
         pending_samples.insert(pending_samples.size(), random_sample());
   endtask

   // Driver: drop the sample on acceptance, hold a stalled one, otherwise offer or idle.
   always @(posedge clock) begin
      if (req_valid && !req_stall)
         pending_samples.delete(0);
      if (!req_valid || !req_stall) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_sample  <= pending_samples[0].sample;
            req_restart <= pending_samples[0].restart;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: serve a long hold-off when one is requested, else stall at the phase rate.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left = HOLD_CYCLES;
         hold_served++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Monitor: check the result transaction first, then predict from the sample transaction,
   // so a maximum is never compared against an expectation queued on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_max.size() == 0) begin
               report_mismatch("window_max with no result pending", rsp_window_max, 'x);
            end else begin
               if (rsp_window_max !== expected_max[0])
                  report_mismatch("window_max", rsp_window_max, expected_max[0]);
               expected_max.delete(0);
               maxima_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            predict_window_max(req_sample, req_restart);
            samples_taken++;
            if (req_restart)
               restarts_taken++;
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed stream at the reset window size: filling the window, both extremes,
      // repeated values, a restart mid-stream, back-to-back restarts and alternating bits.
      queue_sample(16'h0000, 1'b1);
      queue_sample(16'h7FFF, 1'b0);
      queue_sample(16'h8000, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h0001, 1'b0);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'h8000, 1'b0);
      queue_sample(16'h8000, 1'b0);
      queue_sample(16'h8000, 1'b1);
      queue_sample(16'h7FFF, 1'b0);
      queue_sample(16'h7FFF, 1'b0);
      queue_sample(16'h0064, 1'b0);
      queue_sample(16'h0063, 1'b0);
      queue_sample(16'h0062, 1'b0);
      queue_sample(16'h0061, 1'b0);
      queue_sample(16'h5555, 1'b1);
      queue_sample(16'hAAAA, 1'b1);
      queue_sample(16'h5555, 1'b0);
      queue_sample(16'hAAAA, 1'b0);
      queue_sample(16'h2AAA, 1'b0);

      // Random phases. Each write also clears a stream that is still running.
      // Size 0 acts as 1 and 127 as the full 64-deep window.
      run_phase(7'd0,   40,  0,  0, 1'b0);
      run_phase(7'd1,   60, 52,  0, 1'b0);
      run_phase(7'd64, 150,  0, 52, 1'b0);
      run_phase(7'd127, 120, 21, 21, 1'b0);
      // Pressure: the receiver holds off while the sender keeps offering samples.
      run_phase(7'd5,   80,  0,  0, 1'b1);
      run_phase(CSR_WIDTH'($urandom_range(20, 2)), 80, 52, 0, 1'b0);
      run_phase(CSR_WIDTH'($urandom_range(MAX_WINDOW, 1)), 80, 21, 21, 1'b0);

      // Drain, then give a stray late result time to show up.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d samples (%0d restarts) and %0d window maxima over %0d size writes,",
               samples_taken, restarts_taken, maxima_checked, window_writes);
      $display("sizes 0 through 127, sender idling, receiver stalls and a long hold-off.");
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
